// ===== src/cha_pkg.sv =====
// ----------------------------------------------------------------------------
// cha_pkg: shared types and constants of the compacting heap allocator
// Holds the operation and status codes, the controller states, and the
// packet, command and compaction structures that pass between the cells.
// ----------------------------------------------------------------------------
package cha_pkg;

  localparam int ADDR_BITS = 20;
  localparam int LEN_W     = 21;
  localparam int HANDLE_W  = 6;
  localparam int GRANULE   = 8;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NO_HANDLE = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  localparam logic [LEN_W:0] SPAN = (LEN_W + 1)'(1) << ADDR_BITS;
  localparam logic [LEN_W-1:0] HEAP_RESET = LEN_W'(1048576);

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_DONE
  } ctl_state_t;

  typedef struct packed {
    logic             active;
    logic             found;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] len;
  } pkt_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    start;
    logic [LEN_W-1:0]    len;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] len;
  } adj_t;

endpackage

// ===== src/compacting_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// compacting_heap_allocator: handle-based heap that always stays compacted
// Allocate places an 8-byte-rounded block at the end of used space in the
// lowest free handle slot, free releases a slot and slides higher blocks
// down, and lookup reports a handle's current address and length.
// ----------------------------------------------------------------------------
// The block handles one item at a time. Each handle slot is a cell in a
// chain, and an item's packet walks the chain one cell per clock. An
// allocate that fails for lack of space, and a free or lookup of a handle at
// or above HANDLE_SLOTS, is answered without the walk. A result waits in the
// output register while the output is stalled, and the block takes no new
// item until the last result has been loaded into that register. Compaction
// after a free is done by all cells at once in the cycle the packet leaves
// the chain. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module compacting_heap_allocator import cha_pkg::*; #(
  parameter int HANDLE_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LEN_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          op,
  input  logic [LEN_W-1:0]    request_size,
  input  logic [HANDLE_W-1:0] handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [HANDLE_W-1:0] handle_out,
  output logic [ADDR_BITS-1:0] block_address,
  output logic [LEN_W-1:0]    block_length,
  output logic [LEN_W-1:0]    used_bytes
);

  localparam int IDX_W = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;

  ctl_state_t state;
  ctl_state_t state_next;

  logic [LEN_W-1:0]    heap_size;
  logic [LEN_W-1:0]    bytes_in_use;
  logic [1:0]          op_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [LEN_W-1:0]    alloc_len;
  pkt_t                launch_pkt;

  logic [1:0]          pend_status;
  logic [HANDLE_W-1:0] pend_handle;
  logic [LEN_W-1:0]    pend_addr;
  logic [LEN_W-1:0]    pend_len;

  pkt_t                chain_pkt [HANDLE_SLOTS+1];
  logic [IDX_W-1:0]    chain_idx [HANDLE_SLOTS+1];
  cmd_t                cmd;
  adj_t                adj;

  logic                accept;
  logic                scan_end;
  logic                load_out;
  logic [LEN_W:0]      round_len;
  logic [LEN_W:0]      limit;
  logic [LEN_W:0]      avail;
  logic                no_space;
  logic                handle_bad;
  logic                quick;
  pkt_t                end_pkt;
  logic [IDX_W-1:0]    end_idx;
  logic [IDX_W+HANDLE_W-1:0] pick_wide;

  assign end_pkt   = chain_pkt[HANDLE_SLOTS];
  assign end_idx   = chain_idx[HANDLE_SLOTS];
  assign pick_wide = (IDX_W + HANDLE_W)'(end_idx);

  always_comb begin
    round_len  = ({1'b0, request_size} + (LEN_W + 1)'(GRANULE - 1)) &
                 ~(LEN_W + 1)'(GRANULE - 1);
    limit      = ({1'b0, heap_size} < SPAN) ? {1'b0, heap_size} : SPAN;
    avail      = ({1'b0, bytes_in_use} < limit) ? (limit - {1'b0, bytes_in_use})
                                                : '0;
    no_space   = (round_len > avail) || ({1'b0, bytes_in_use} >= SPAN);
    handle_bad = 32'(handle) >= HANDLE_SLOTS;
    quick      = (op == OP_ALLOC) ? no_space : handle_bad;
  end

  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: begin
        if (in_valid) begin
          state_next = quick ? CTL_DONE : CTL_SCAN;
        end
      end
      CTL_SCAN: begin
        if (end_pkt.active) begin
          state_next = CTL_DONE;
        end
      end
      CTL_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = CTL_IDLE;
        end
      end
      default: state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    scan_end = 1'b0;
    load_out = 1'b0;
    case (state)
      CTL_IDLE: in_stall = 1'b0;
      CTL_SCAN: scan_end = end_pkt.active;
      CTL_DONE: load_out = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
    accept   = in_valid && !in_stall;
    adj.en   = scan_end && (op_r == OP_FREE) && end_pkt.found;
    adj.base = end_pkt.start;
    adj.len  = end_pkt.len;
  end

  always_ff @(posedge clk) begin
    launch_pkt.found <= 1'b0;
    launch_pkt.start <= '0;
    launch_pkt.len   <= '0;
    if (rst) begin
      state             <= CTL_IDLE;
      heap_size         <= HEAP_RESET;
      bytes_in_use      <= '0;
      launch_pkt.active <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      launch_pkt.active <= accept && !quick;
      if (cfg_we) begin
        heap_size <= cfg_data;
      end
      if (scan_end && end_pkt.found) begin
        if (op_r == OP_ALLOC) begin
          bytes_in_use <= bytes_in_use + end_pkt.len;
        end else if (op_r == OP_FREE) begin
          bytes_in_use <= bytes_in_use - end_pkt.len;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= op;
      handle_r  <= handle;
      alloc_len <= round_len[LEN_W-1:0];
      if (op == OP_ALLOC) begin
        pend_status <= no_space ? ST_NO_SPACE : ST_OK;
        pend_handle <= '0;
      end else begin
        pend_status <= handle_bad ? ST_BAD_HANDLE : ST_OK;
        pend_handle <= handle;
      end
      pend_addr <= '0;
      pend_len  <= '0;
    end
    if (scan_end) begin
      if (end_pkt.found) begin
        pend_status <= ST_OK;
        pend_handle <= (op_r == OP_ALLOC) ? pick_wide[HANDLE_W-1:0] : handle_r;
        pend_addr   <= end_pkt.start;
        pend_len    <= end_pkt.len;
      end else begin
        pend_status <= (op_r == OP_ALLOC) ? ST_NO_HANDLE : ST_BAD_HANDLE;
        pend_handle <= (op_r == OP_ALLOC) ? '0 : handle_r;
        pend_addr   <= '0;
        pend_len    <= '0;
      end
    end
    if (load_out) begin
      status        <= pend_status;
      handle_out    <= pend_handle;
      block_address <= pend_addr[ADDR_BITS-1:0];
      block_length  <= pend_len;
      used_bytes    <= bytes_in_use;
    end
  end

  assign cmd.op     = op_r;
  assign cmd.handle = handle_r;
  assign cmd.start  = bytes_in_use;
  assign cmd.len    = alloc_len;

  assign chain_pkt[0] = launch_pkt;
  assign chain_idx[0] = '0;

  for (genvar i = 0; i < HANDLE_SLOTS; i++) begin : g_cell
    cha_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .adj     (adj),
      .pkt_in  (chain_pkt[i]),
      .idx_in  (chain_idx[i]),
      .pkt_out (chain_pkt[i+1]),
      .idx_out (chain_idx[i+1])
    );
  end

`ifndef SYNTHESIS
  a_used_in_span: assert property (@(posedge clk) disable iff (rst)
    {1'b0, bytes_in_use} <= SPAN)
    else $error("Used bytes exceed the address span.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != CTL_IDLE))
    else $error("Controller stayed idle after taking an item.");

  a_end_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    end_pkt.active |-> (state == CTL_SCAN))
    else $error("Packet left the chain outside a scan.");

  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && (state == CTL_IDLE)))
    else $error("Result load did not present a result.");
`endif

endmodule

// ===== src/cha_cell.sv =====
// ----------------------------------------------------------------------------
// cha_cell: one handle slot of the compacting heap allocator
// Holds the slot's valid flag, start and length, claims or releases itself as
// the scan packet passes, and slides its block down during compaction.
// ----------------------------------------------------------------------------
module cha_cell import cha_pkg::*; #(
  parameter int INDEX = 0,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  adj_t             adj,
  input  pkt_t             pkt_in,
  input  logic [IDX_W-1:0] idx_in,
  output pkt_t             pkt_out,
  output logic [IDX_W-1:0] idx_out
);

  logic             slot_valid;
  logic [LEN_W-1:0] slot_start;
  logic [LEN_W-1:0] slot_length;

  logic             hit_alloc;
  logic             hit_handle;
  logic             slide;
  pkt_t             pkt_next;
  logic [IDX_W-1:0] idx_next;

  always_comb begin
    hit_alloc  = pkt_in.active && (cmd.op == OP_ALLOC) && !pkt_in.found && !slot_valid;
    hit_handle = pkt_in.active && (cmd.op != OP_ALLOC) && slot_valid &&
                 (32'(cmd.handle) == INDEX);
    slide      = adj.en && slot_valid && (slot_start > adj.base);
    pkt_next   = pkt_in;
    idx_next   = idx_in;
    if (hit_alloc) begin
      pkt_next.found = 1'b1;
      pkt_next.start = cmd.start;
      pkt_next.len   = cmd.len;
      idx_next       = IDX_W'(INDEX);
    end else if (hit_handle) begin
      pkt_next.found = 1'b1;
      pkt_next.start = slot_start;
      pkt_next.len   = slot_length;
      idx_next       = IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    pkt_out.found <= pkt_next.found;
    pkt_out.start <= pkt_next.start;
    pkt_out.len   <= pkt_next.len;
    idx_out       <= idx_next;
    if (hit_alloc) begin
      slot_start  <= cmd.start;
      slot_length <= cmd.len;
    end else if (slide) begin
      slot_start <= slot_start - adj.len;
    end
    if (rst) begin
      slot_valid     <= 1'b0;
      pkt_out.active <= 1'b0;
    end else begin
      pkt_out.active <= pkt_next.active;
      if (hit_alloc) begin
        slot_valid <= 1'b1;
      end else if (hit_handle && (cmd.op == OP_FREE)) begin
        slot_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the compacting heap allocator
// A directed run covers invalid handles, zero-length and oversized requests,
// a full heap and compaction after frees. Random phases then follow under
// several heap sizes with random idling on both sides. Every reply is checked
// against a software copy of the heap bookkeeping.
// ----------------------------------------------------------------------------
module testbench;
  import cha_pkg::*;

  localparam int SLOTS = 64;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 90;
  localparam logic [1:0] OP_LOOKUP_ALT = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [LEN_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           op;
  logic [LEN_W-1:0]     request_size;
  logic [HANDLE_W-1:0]  handle;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           status;
  logic [HANDLE_W-1:0]  handle_out;
  logic [ADDR_BITS-1:0] block_address;
  logic [LEN_W-1:0]     block_length;
  logic [LEN_W-1:0]     used_bytes;

  logic calm = 1'b0;
  logic holding = 1'b0;
  int   taken = 0;
  int   quiet = 0;

  compacting_heap_allocator #(.HANDLE_SLOTS(SLOTS)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .request_size(request_size), .handle(handle),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .handle_out(handle_out), .block_address(block_address),
    .block_length(block_length), .used_bytes(used_bytes)
  );

  typedef struct packed {
    logic [1:0]           status;
    logic [HANDLE_W-1:0]  handle_out;
    logic [ADDR_BITS-1:0] address;
    logic [LEN_W-1:0]     length;
    logic [LEN_W-1:0]     used;
  } reply_t;

  class heap_book;
    bit                   live [SLOTS];
    bit [ADDR_BITS-1:0]   base_of [SLOTS];
    bit [LEN_W-1:0]       len_of [SLOTS];
    bit [LEN_W-1:0]       in_use;
    bit [LEN_W-1:0]       heap_size;
    reply_t               due_replies [$];
    int                   errors;

    function new();
      heap_size = HEAP_RESET;
    endfunction

    function int pending();
      return due_replies.size();
    endfunction

    function int pick_live();
      int idx [$];
      foreach (live[i]) if (live[i]) idx.push_back(i);
      if (idx.size() == 0) return -1;
      return idx[$urandom_range(0, idx.size() - 1)];
    endfunction

    function reply_t apply(logic [1:0] code, logic [LEN_W-1:0] req,
                           logic [HANDLE_W-1:0] h);
      reply_t r;
      bit [LEN_W:0] need;
      bit [LEN_W-1:0] cap, room, gone;
      bit [ADDR_BITS-1:0] at;
      int pick;
      r = '0;
      pick = -1;
      if (code == OP_ALLOC) begin
        need = ({1'b0, req} + (LEN_W + 1)'(GRANULE - 1)) & ~((LEN_W + 1)'(GRANULE - 1));
        cap = (heap_size < SPAN) ? heap_size : SPAN[LEN_W-1:0];
        room = (in_use < cap) ? cap - in_use : '0;
        if (need > room || in_use >= SPAN) begin
          r.status = ST_NO_SPACE;
        end else begin
          for (int i = SLOTS - 1; i >= 0; i--) if (!live[i]) pick = i;
          if (pick < 0) begin
            r.status = ST_NO_HANDLE;
          end else begin
            live[pick] = 1'b1;
            base_of[pick] = in_use[ADDR_BITS-1:0];
            len_of[pick] = need[LEN_W-1:0];
            in_use += need[LEN_W-1:0];
            r.status = ST_OK;
            r.handle_out = HANDLE_W'(pick);
            r.address = base_of[pick];
            r.length = len_of[pick];
          end
        end
      end else begin
        r.handle_out = h;
        if (!live[h]) begin
          r.status = ST_BAD_HANDLE;
        end else if (code == OP_FREE) begin
          at = base_of[h];
          gone = len_of[h];
          live[h] = 1'b0;
          foreach (live[i]) if (live[i] && base_of[i] > at) base_of[i] -= gone[ADDR_BITS-1:0];
          in_use -= gone;
          r.status = ST_OK;
          r.address = at;
          r.length = gone;
        end else begin
          r.status = ST_OK;
          r.address = base_of[h];
          r.length = len_of[h];
        end
      end
      r.used = in_use;
      return r;
    endfunction

    task note_request(logic [1:0] code, logic [LEN_W-1:0] req, logic [HANDLE_W-1:0] h);
      due_replies.push_back(apply(code, req, h));
    endtask

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [LEN_W-1:0] got, logic [LEN_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_reply(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        report($sformatf("reply with no request outstanding: %p", got));
        return;
      end
      want = due_replies.pop_front();
      compare("status", LEN_W'(got.status), LEN_W'(want.status));
      compare("handle_out", LEN_W'(got.handle_out), LEN_W'(want.handle_out));
      compare("block_address", LEN_W'(got.address), LEN_W'(want.address));
      compare("block_length", got.length, want.length);
      compare("used_bytes", got.used, want.used);
    endtask
  endclass

  heap_book book = new();

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        book.note_request(op, request_size, handle);
        taken <= taken + 1;
      end
      if (out_valid && !out_stall)
        book.check_reply({status, handle_out, block_address, block_length, used_bytes});
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holding) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  initial begin
    wait (taken >= 400);
    @(posedge clk);
    holding <= 1'b1;
    repeat (400) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic offer(logic [1:0] code, logic [LEN_W-1:0] req, logic [HANDLE_W-1:0] h);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    request_size <= req;
    handle <= h;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_heap(logic [LEN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.heap_size = value;
  endtask

  function automatic logic [LEN_W-1:0] draw_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return LEN_W'($urandom_range(0, 64));
    if (k < 85) return LEN_W'($urandom_range(0, 8192));
    if (k < 95) return LEN_W'($urandom_range(0, 1 << 20));
    return LEN_W'($urandom);
  endfunction

  task automatic random_item(int alloc_pct);
    int h;
    logic [1:0] code;
    if ($urandom_range(0, 99) < alloc_pct) begin
      offer(OP_ALLOC, draw_size(), HANDLE_W'($urandom));
    end else begin
      h = book.pick_live();
      if (h < 0 || $urandom_range(0, 3) == 0) h = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 1) == 1) code = OP_FREE;
      else if ($urandom_range(0, 7) == 0) code = OP_LOOKUP_ALT;
      else code = OP_LOOKUP;
      offer(code, LEN_W'($urandom), HANDLE_W'(h));
    end
  endtask

  initial begin
    logic [LEN_W-1:0] heap_plan [PHASES];
    int alloc_plan [PHASES];
    heap_plan = '{HEAP_RESET, 21'h1FFFFF, 21'd0, 21'd64, 21'd4096, 21'd1048575,
                  21'd65536, 21'd0};
    alloc_plan = '{80, 60, 40, 85, 50, 70, 30, 0};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= OP_ALLOC;
    request_size <= '0;
    handle <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_heap(HEAP_RESET);

    offer(OP_LOOKUP, 21'd0, 6'd0);
    offer(OP_FREE, 21'h1FFFFF, 6'd63);
    offer(OP_LOOKUP_ALT, 21'd0, 6'd5);
    offer(OP_ALLOC, 21'd0, 6'd0);
    offer(OP_ALLOC, 21'd1, 6'd0);
    offer(OP_ALLOC, 21'd8, 6'd0);
    offer(OP_ALLOC, 21'd9, 6'd63);
    offer(OP_ALLOC, 21'h1FFFFF, 6'd0);
    offer(OP_LOOKUP, 21'd0, 6'd3);
    offer(OP_LOOKUP_ALT, 21'd0, 6'd2);
    offer(OP_FREE, 21'd0, 6'd1);
    offer(OP_LOOKUP, 21'd0, 6'd2);
    offer(OP_LOOKUP, 21'd0, 6'd3);
    offer(OP_FREE, 21'd0, 6'd0);
    offer(OP_FREE, 21'd0, 6'd2);
    offer(OP_FREE, 21'd0, 6'd3);
    offer(OP_ALLOC, 21'd1048576, 6'd0);
    offer(OP_ALLOC, 21'd0, 6'd0);
    offer(OP_LOOKUP, 21'd0, 6'd0);
    offer(OP_FREE, 21'd0, 6'd0);
    offer(OP_ALLOC, 21'd1048569, 6'd0);
    offer(OP_FREE, 21'd0, 6'd0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      calm <= (p == 2);
      if (p == PHASES - 1) begin
        heap_plan[p] = LEN_W'($urandom);
        alloc_plan[p] = $urandom_range(30, 85);
      end
      write_heap(heap_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) random_item(alloc_plan[p]);
    end

    drain();
    repeat (SLOTS + 4) @(posedge clk);
    if (book.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
